@@ rtl/core/glb_chk_pkg.sv @@
// Package for the binary glTF container checker.
// Holds container constants, status codes, the parse phase type and the
// structs that pass between the checker modules. Depends on nothing.
package glb_chk_pkg;

    // Container format constants.
    localparam logic [31:0] GLB_MAGIC         = 32'h4654_6c67;
    localparam logic [31:0] KIND_JSON         = 32'h4e4f_534a;
    localparam logic [31:0] KIND_BIN          = 32'h004e_4942;
    localparam logic [31:0] GLB_VERSION       = 32'd2;
    localparam logic [15:0] LIMIT_RESET       = 16'd4096;
    localparam logic [31:0] MIN_BINARY_SIZE   = 32'd20;
    localparam logic [3:0]  FILE_HEADER_SIZE  = 4'd12;
    localparam int          CHUNK_HEADER_SIZE = 8;
    localparam int          FILL_W            = $clog2(CHUNK_HEADER_SIZE);

    // Verdict status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HEADER    = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_CHUNK_LEN = 3'd3;
    localparam logic [2:0] ST_JSON_ORD  = 3'd4;
    localparam logic [2:0] ST_BIN_ORD   = 3'd5;
    localparam logic [2:0] ST_NO_JSON   = 3'd6;
    localparam logic [2:0] ST_TOO_MANY  = 3'd7;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER    = 4'b0001,
        PH_CHUNK_HDR = 4'b0010,
        PH_BODY      = 4'b0100,
        PH_IDLE      = 4'b1000
    } phase_t;

    // One input byte as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    // One verdict.
    typedef struct packed {
        logic [2:0]  status;
        logic        is_binary;
        logic [31:0] json_offset;
        logic [31:0] json_length;
        logic        bin_present;
        logic [31:0] bin_offset;
        logic [31:0] bin_length;
        logic [15:0] chunk_count;
    } verdict_t;

endpackage

@@ rtl/core/glb_chk_ifs.sv @@
// Channel interfaces of the container checker: byte input and verdict output.
// Does not depend on glb_chk_pkg; its field widths match the package structs.
interface glb_chk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface glb_chk_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        is_binary;
    logic [31:0] json_offset;
    logic [31:0] json_length;
    logic        bin_present;
    logic [31:0] bin_offset;
    logic [31:0] bin_length;
    logic [15:0] chunk_count;

    modport source (output valid, output status, output is_binary, output json_offset,
                    output json_length, output bin_present, output bin_offset,
                    output bin_length, output chunk_count, input ready);
    modport sink   (input valid, input status, input is_binary, input json_offset,
                    input json_length, input bin_present, input bin_offset,
                    input bin_length, input chunk_count, output ready);
endinterface

@@ rtl/core/glb_chk_in_stage.sv @@
// Input register of the container checker.
// Depends on glb_chk_pkg and glb_chk_byte_if.
module glb_chk_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    glb_chk_byte_if.sink         item,
    input  logic                 out_free,
    output logic                 step_en,
    output glb_chk_pkg::item_t   cur_item
);

    logic                valid_reg;
    glb_chk_pkg::item_t  item_reg;
    logic                advance;

    // A non-final byte always moves on; a final byte needs room for its verdict.
    assign advance    = !item_reg.final_byte || out_free;
    assign step_en    = valid_reg && advance;
    assign item.ready = !valid_reg || advance;
    assign cur_item   = item_reg;

    // Hold flag of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    // Payload is captured on every transfer.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.data_byte  <= item.data_byte;
            item_reg.final_byte <= item.final_byte;
        end
    end

endmodule

@@ rtl/core/glb_chk_core.sv @@
// Parse state of the container checker: file header, chunk headers, chunk
// bodies, chunk judgement and the verdict. Depends on glb_chk_pkg.
module glb_chk_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [15:0]             cfg_wr_data,
    input  logic                    step_en,
    input  glb_chk_pkg::item_t      cur_item,
    output logic                    res_valid,
    output glb_chk_pkg::verdict_t   res
);

    localparam logic [glb_chk_pkg::FILL_W-1:0] FILL_LAST =
        glb_chk_pkg::FILL_W'(glb_chk_pkg::CHUNK_HEADER_SIZE - 1);

    logic [15:0]                   limit_reg;
    logic [31:0]                   pos_reg,   pos_next;
    logic [32:0]                   off_reg,   off_next;
    logic [31:0]                   hword_reg, hword_next;
    logic [31:0]                   decl_reg,  decl_next;
    logic                          binf_reg,  binf_next;
    logic                          herr_reg,  herr_next;
    glb_chk_pkg::phase_t           phase_reg, phase_next;
    logic [63:0]                   lk_reg,    lk_next;
    logic [31:0]                   rem_reg,   rem_next;
    logic                          jseen_reg, jseen_next;
    logic                          bseen_reg, bseen_next;
    logic [15:0]                   acc_reg,   acc_next;
    logic [2:0]                    ferr_reg,  ferr_next;
    logic [31:0]                   joff_reg,  joff_next;
    logic [31:0]                   jlen_reg,  jlen_next;
    logic [31:0]                   boff_reg,  boff_next;
    logic [31:0]                   blen_reg,  blen_next;
    logic [glb_chk_pkg::FILL_W-1:0] fill_reg, fill_next;

    logic [7:0]  b;
    logic [31:0] hw_new;
    logic [63:0] lk_new;
    logic [31:0] len;
    logic [31:0] kind;
    logic        fit_bad;
    logic [2:0]  jerr;
    logic [31:0] rem_dec;
    logic [2:0]  fe_fin;
    logic        hdr_bad;
    logic [2:0]  status;

    assign b      = cur_item.data_byte;
    assign hw_new = hword_reg | (32'(b) << {pos_reg[1:0], 3'b000});
    assign lk_new = lk_reg | (64'(b) << {fill_reg, 3'b000});
    assign len    = lk_reg[31:0];
    assign kind   = {b, lk_reg[55:32]};

    // Chunk fit against the declared length: room is zero once the offset passes it.
    always_comb
    begin
        if ({1'b0, decl_reg} < off_reg)
        begin
            fit_bad = (len != 32'd0);
        end
        else
        begin
            fit_bad = ({2'b00, len} + {1'b0, off_reg}) > {2'b00, decl_reg};
        end
    end

    // Chunk judgement: length and alignment, order rules, then the count limit.
    always_comb
    begin
        jerr = glb_chk_pkg::ST_OK;
        if ((len[1:0] != 2'b00) || fit_bad)
        begin
            jerr = glb_chk_pkg::ST_CHUNK_LEN;
        end
        else if (kind == glb_chk_pkg::KIND_JSON)
        begin
            if (jseen_reg || (acc_reg != 16'd0) || (len == 32'd0))
            begin
                jerr = glb_chk_pkg::ST_JSON_ORD;
            end
        end
        else if (kind == glb_chk_pkg::KIND_BIN)
        begin
            if (!jseen_reg || bseen_reg || (acc_reg != 16'd1))
            begin
                jerr = glb_chk_pkg::ST_BIN_ORD;
            end
        end
        else if (!jseen_reg)
        begin
            jerr = glb_chk_pkg::ST_NO_JSON;
        end
        if ((jerr == glb_chk_pkg::ST_OK) && (acc_reg >= limit_reg))
        begin
            jerr = glb_chk_pkg::ST_TOO_MANY;
        end
    end

    assign rem_dec = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;

    // Next parse state for one byte.
    always_comb
    begin
        hword_next = hword_reg;
        decl_next  = decl_reg;
        binf_next  = binf_reg;
        herr_next  = herr_reg;
        phase_next = phase_reg;
        lk_next    = lk_reg;
        rem_next   = rem_reg;
        jseen_next = jseen_reg;
        bseen_next = bseen_reg;
        acc_next   = acc_reg;
        ferr_next  = ferr_reg;
        joff_next  = joff_reg;
        jlen_next  = jlen_reg;
        boff_next  = boff_reg;
        blen_next  = blen_reg;
        fill_next  = fill_reg;
        unique case (phase_reg)
            glb_chk_pkg::PH_HEADER:
            begin
                if ((pos_reg[31:4] == 28'd0) && (pos_reg[3:0] < glb_chk_pkg::FILE_HEADER_SIZE))
                begin
                    hword_next = hw_new;
                    if (pos_reg[1:0] == 2'b11)
                    begin
                        hword_next = 32'd0;
                        unique case (pos_reg[3:2])
                            2'd0:
                            begin
                                binf_next = (hw_new == glb_chk_pkg::GLB_MAGIC);
                                if (hw_new != glb_chk_pkg::GLB_MAGIC)
                                begin
                                    phase_next = glb_chk_pkg::PH_IDLE;
                                end
                            end
                            2'd1:
                            begin
                                herr_next = (hw_new != glb_chk_pkg::GLB_VERSION);
                            end
                            default:
                            begin
                                decl_next  = hw_new;
                                phase_next = glb_chk_pkg::PH_CHUNK_HDR;
                                fill_next  = '0;
                            end
                        endcase
                    end
                end
                else
                begin
                    phase_next = glb_chk_pkg::PH_IDLE;
                end
            end
            glb_chk_pkg::PH_CHUNK_HDR:
            begin
                lk_next   = lk_new;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == FILL_LAST)
                begin
                    lk_next = 64'd0;
                    if (jerr != glb_chk_pkg::ST_OK)
                    begin
                        ferr_next  = jerr;
                        phase_next = glb_chk_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (kind == glb_chk_pkg::KIND_JSON)
                        begin
                            joff_next  = off_reg[31:0];
                            jlen_next  = len;
                            jseen_next = 1'b1;
                        end
                        else if (kind == glb_chk_pkg::KIND_BIN)
                        begin
                            boff_next  = off_reg[31:0];
                            blen_next  = len;
                            bseen_next = 1'b1;
                        end
                        acc_next = acc_reg + 16'd1;
                        if (len != 32'd0)
                        begin
                            rem_next   = len;
                            phase_next = glb_chk_pkg::PH_BODY;
                        end
                    end
                end
            end
            glb_chk_pkg::PH_BODY:
            begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    phase_next = glb_chk_pkg::PH_CHUNK_HDR;
                end
            end
            glb_chk_pkg::PH_IDLE:
            begin
                phase_next = glb_chk_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = glb_chk_pkg::PH_IDLE;
            end
        endcase
    end

    // Saturating byte counter and the offset of the next byte.
    assign pos_next = (&pos_reg) ? pos_reg : pos_reg + 32'd1;
    assign off_next = (&pos_reg) ? off_reg : off_reg + 33'd1;

    // Verdict for a final byte; a half-read chunk header counts as truncation.
    always_comb
    begin
        fe_fin = ferr_next;
        if ((phase_next == glb_chk_pkg::PH_CHUNK_HDR) && (fill_next != '0)
            && (ferr_next == glb_chk_pkg::ST_OK))
        begin
            fe_fin = glb_chk_pkg::ST_TRUNC;
        end
        hdr_bad = (pos_next < glb_chk_pkg::MIN_BINARY_SIZE) || herr_next
                  || (decl_next != pos_next);
        status  = hdr_bad ? glb_chk_pkg::ST_HEADER : fe_fin;

        res = '0;
        if (binf_next)
        begin
            res.status      = status;
            res.is_binary   = 1'b1;
            res.chunk_count = acc_next;
            if (status == glb_chk_pkg::ST_OK)
            begin
                res.json_offset = joff_next;
                res.json_length = jlen_next;
                res.bin_present = bseen_next;
                res.bin_offset  = boff_next;
                res.bin_length  = blen_next;
            end
        end
        else
        begin
            res.json_length = pos_next;
        end
    end

    assign res_valid = step_en && cur_item.final_byte;

    // Chunk limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= glb_chk_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Parse state; a final byte returns it to the start of a new file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            off_reg   <= 33'd1;
            hword_reg <= '0;
            decl_reg  <= '0;
            binf_reg  <= 1'b0;
            herr_reg  <= 1'b0;
            phase_reg <= glb_chk_pkg::PH_HEADER;
            lk_reg    <= '0;
            rem_reg   <= '0;
            jseen_reg <= 1'b0;
            bseen_reg <= 1'b0;
            acc_reg   <= '0;
            ferr_reg  <= glb_chk_pkg::ST_OK;
            joff_reg  <= '0;
            jlen_reg  <= '0;
            boff_reg  <= '0;
            blen_reg  <= '0;
            fill_reg  <= '0;
        end
        else if (step_en)
        begin
            if (cur_item.final_byte)
            begin
                pos_reg   <= '0;
                off_reg   <= 33'd1;
                hword_reg <= '0;
                decl_reg  <= '0;
                binf_reg  <= 1'b0;
                herr_reg  <= 1'b0;
                phase_reg <= glb_chk_pkg::PH_HEADER;
                lk_reg    <= '0;
                rem_reg   <= '0;
                jseen_reg <= 1'b0;
                bseen_reg <= 1'b0;
                acc_reg   <= '0;
                ferr_reg  <= glb_chk_pkg::ST_OK;
                joff_reg  <= '0;
                jlen_reg  <= '0;
                boff_reg  <= '0;
                blen_reg  <= '0;
                fill_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                off_reg   <= off_next;
                hword_reg <= hword_next;
                decl_reg  <= decl_next;
                binf_reg  <= binf_next;
                herr_reg  <= herr_next;
                phase_reg <= phase_next;
                lk_reg    <= lk_next;
                rem_reg   <= rem_next;
                jseen_reg <= jseen_next;
                bseen_reg <= bseen_next;
                acc_reg   <= acc_next;
                ferr_reg  <= ferr_next;
                joff_reg  <= joff_next;
                jlen_reg  <= jlen_next;
                boff_reg  <= boff_next;
                blen_reg  <= blen_next;
                fill_reg  <= fill_next;
            end
        end
    end

endmodule

@@ rtl/core/glb_chk_out_reg.sv @@
// Result register of the container checker; drives the verdict channel.
// Depends on glb_chk_pkg and glb_chk_verdict_if.
module glb_chk_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  glb_chk_pkg::verdict_t   res,
    output logic                    out_free,
    glb_chk_verdict_if.source       verdict
);

    logic                   valid_reg;
    glb_chk_pkg::verdict_t  data_reg;

    // The slot can take a new verdict when empty or when its transfer completes.
    assign out_free = !valid_reg || verdict.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_valid;
        end
    end

    // Verdict payload.
    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign verdict.valid       = valid_reg;
    assign verdict.status      = data_reg.status;
    assign verdict.is_binary   = data_reg.is_binary;
    assign verdict.json_offset = data_reg.json_offset;
    assign verdict.json_length = data_reg.json_length;
    assign verdict.bin_present = data_reg.bin_present;
    assign verdict.bin_offset  = data_reg.bin_offset;
    assign verdict.bin_length  = data_reg.bin_length;
    assign verdict.chunk_count = data_reg.chunk_count;

endmodule

@@ rtl/core/glb_container_chunk_checker.sv @@
// Binary glTF container checker, top level.
// The final byte passes from the input register through the parse state into the result
// register, which drives the verdict channel.
// Throughput: one byte per cycle, set by the input register feeding the parse
// state; a final byte waits only while a previous verdict is still not taken.
// Reset (rst_n, asynchronous, active low) clears the parse state and the valid
// flags of both registers and sets the chunk limit to 4096. Depends on glb_chk_pkg, the
// interfaces, glb_chk_in_stage, glb_chk_core and glb_chk_out_reg.
module glb_container_chunk_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    glb_chk_byte_if.sink        item,
    glb_chk_verdict_if.source   verdict
);

    logic                   out_free;
    logic                   step_en;
    glb_chk_pkg::item_t     cur_item;
    logic                   res_valid;
    glb_chk_pkg::verdict_t  res;

    // Input register.
    glb_chk_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .out_free (out_free),
        .step_en  (step_en),
        .cur_item (cur_item)
    );

    // Parse state and verdict logic.
    glb_chk_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .cur_item    (cur_item),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register.
    glb_chk_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .verdict   (verdict)
    );

endmodule

@@ tb/tb_glb_container_chunk_checker.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the binary glTF container checker.
// Depends on glb_chk_pkg, the channel interfaces and glb_container_chunk_checker.
module tb_glb_container_chunk_checker;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LATENCY_PAD     = 4;
    localparam int BYTES_PER_LIMIT = 140;
    localparam int FILES_PER_LIMIT = 2;
    localparam int MAX_REPORTS     = 50;
    localparam int RANDOM_LIMIT    = -1;

    // Directed file shapes.
    typedef enum int {
        SH_PLAIN,
        SH_MAGIC,
        SH_GLB,
        SH_BAD_VER,
        SH_BAD_LEN,
        SH_JSON_EMPTY,
        SH_BIN_FIRST,
        SH_OTHER_FIRST,
        SH_JSON_TWICE,
        SH_BIN_TWICE,
        SH_UNALIGNED,
        SH_OVERSIZE,
        SH_CUT_HDR,
        SH_THREE,
        SH_MID_OTHER,
        SH_TRAILING
    } shape_t;

    typedef struct {
        shape_t                shape;
        int                    a;
        int                    b;
        bit                    typed;
        glb_chk_pkg::verdict_t want;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [15:0] cfg_wr_data;

    glb_chk_byte_if    byte_ch ();
    glb_chk_verdict_if verdict_ch ();

    glb_container_chunk_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (byte_ch),
        .verdict     (verdict_ch)
    );

    // Parser state mirrored by the predictor.
    logic [31:0] byte_count;
    logic [31:0] word_acc;
    logic [31:0] declared_len;
    logic        glb_file;
    logic        bad_version;
    glb_chk_pkg::phase_t phase;
    logic [63:0] chunk_hdr;
    logic [31:0] body_left;
    logic        json_found;
    logic        bin_found;
    logic [15:0] chunks_taken;
    logic [2:0]  first_err;
    logic [31:0] json_off;
    logic [31:0] json_len;
    logic [31:0] bin_off;
    logic [31:0] bin_len;
    int          hdr_bytes;
    logic [15:0] chunk_limit;

    glb_chk_pkg::verdict_t verdicts_due[$];
    logic [7:0]  file_bytes[$];
    row_t        plan[$];

    // Chunk list used to build binary files.
    logic [31:0] plan_kind[8];
    logic [31:0] plan_field[8];
    int          plan_body[8];
    int          plan_n;

    int  fail_count;
    int  cycle_count;
    int  bytes_sent;
    int  files_sent;
    int  verdicts_seen;
    int  settings_used;
    int  status_seen[8];
    bit  tx_calm;
    bit  rx_calm;
    int  rx_stall;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short idle stretches, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic glb_chk_pkg::verdict_t verdict_of(input logic [2:0] st,
                                            input logic isb,
                                            input logic [31:0] jo, input logic [31:0] jl,
                                            input logic bp, input logic [31:0] bo,
                                            input logic [31:0] bl, input logic [15:0] cc);
        glb_chk_pkg::verdict_t v;
        v.status      = st;
        v.is_binary   = isb;
        v.json_offset = jo;
        v.json_length = jl;
        v.bin_present = bp;
        v.bin_offset  = bo;
        v.bin_length  = bl;
        v.chunk_count = cc;
        return v;
    endfunction

    function automatic row_t plan_row(input shape_t s, input int a, input int b,
                                      input bit typed, input glb_chk_pkg::verdict_t w);
        row_t r;
        r.shape = s;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.want  = w;
        return r;
    endfunction

    // Return the parser to its state at the start of a file.
    function automatic void clear_parse();
        byte_count   = '0;
        word_acc     = '0;
        declared_len = '0;
        glb_file     = 1'b0;
        bad_version  = 1'b0;
        phase        = glb_chk_pkg::PH_HEADER;
        chunk_hdr    = '0;
        body_left    = '0;
        json_found   = 1'b0;
        bin_found    = 1'b0;
        chunks_taken = '0;
        first_err    = glb_chk_pkg::ST_OK;
        json_off     = '0;
        json_len     = '0;
        bin_off      = '0;
        bin_len      = '0;
        hdr_bytes    = 0;
    endfunction

    // Judge a complete chunk header whose last byte sits at position p.
    function automatic void accept_chunk(input logic [31:0] p);
        logic [31:0] len;
        logic [31:0] kind;
        logic [32:0] off;
        logic [32:0] room;
        logic [2:0]  err;
        len  = chunk_hdr[31:0];
        kind = chunk_hdr[63:32];
        off  = {1'b0, p} + 33'd1;
        room = ({1'b0, declared_len} >= off) ? {1'b0, declared_len} - off : 33'd0;
        err  = glb_chk_pkg::ST_OK;
        if (len[1:0] != 2'd0 || {1'b0, len} > room)
            err = glb_chk_pkg::ST_CHUNK_LEN;
        else if (kind == glb_chk_pkg::KIND_JSON)
        begin
            if (json_found || chunks_taken != 16'd0 || len == 32'd0)
                err = glb_chk_pkg::ST_JSON_ORD;
        end
        else if (kind == glb_chk_pkg::KIND_BIN)
        begin
            if (!json_found || bin_found || chunks_taken != 16'd1)
                err = glb_chk_pkg::ST_BIN_ORD;
        end
        else if (!json_found)
            err = glb_chk_pkg::ST_NO_JSON;
        if (err == glb_chk_pkg::ST_OK && chunks_taken >= chunk_limit)
            err = glb_chk_pkg::ST_TOO_MANY;

        if (err != glb_chk_pkg::ST_OK)
        begin
            first_err = err;
            phase     = glb_chk_pkg::PH_IDLE;
            return;
        end
        if (kind == glb_chk_pkg::KIND_JSON)
        begin
            json_off   = off[31:0];
            json_len   = len;
            json_found = 1'b1;
        end
        else if (kind == glb_chk_pkg::KIND_BIN)
        begin
            bin_off   = off[31:0];
            bin_len   = len;
            bin_found = 1'b1;
        end
        chunks_taken = chunks_taken + 16'd1;
        if (len != 32'd0)
        begin
            body_left = len;
            phase     = glb_chk_pkg::PH_BODY;
        end
        else
            phase = glb_chk_pkg::PH_CHUNK_HDR;
    endfunction

    // Advance the parser by one byte; returns 1 with the verdict on a final byte.
    function automatic bit predict_byte(input logic [7:0] b, input logic fin,
                                        output glb_chk_pkg::verdict_t v);
        logic [31:0] p;
        logic [31:0] w;
        logic [2:0]  st;
        p = byte_count;
        v = '0;
        case (phase)
            glb_chk_pkg::PH_HEADER:
            begin
                if (p < glb_chk_pkg::FILE_HEADER_SIZE)
                begin
                    word_acc = word_acc | ({24'd0, b} << (8 * p[1:0]));
                    if (p[1:0] == 2'd3)
                    begin
                        w        = word_acc;
                        word_acc = '0;
                        if (p == 32'd3)
                        begin
                            glb_file = (w == glb_chk_pkg::GLB_MAGIC);
                            if (!glb_file)
                                phase = glb_chk_pkg::PH_IDLE;
                        end
                        else if (p == 32'd7)
                            bad_version = (w != glb_chk_pkg::GLB_VERSION);
                        else
                        begin
                            declared_len = w;
                            phase        = glb_chk_pkg::PH_CHUNK_HDR;
                            hdr_bytes    = 0;
                        end
                    end
                end
                else
                    phase = glb_chk_pkg::PH_IDLE;
            end
            glb_chk_pkg::PH_CHUNK_HDR:
            begin
                chunk_hdr = chunk_hdr | ({56'd0, b} << (8 * hdr_bytes));
                hdr_bytes++;
                if (hdr_bytes >= glb_chk_pkg::CHUNK_HEADER_SIZE)
                begin
                    hdr_bytes = 0;
                    accept_chunk(p);
                    chunk_hdr = '0;
                end
            end
            glb_chk_pkg::PH_BODY:
            begin
                if (body_left != 32'd0)
                    body_left--;
                if (body_left == 32'd0)
                    phase = glb_chk_pkg::PH_CHUNK_HDR;
            end
            default:
            begin
            end
        endcase

        if (byte_count != 32'hFFFF_FFFF)
            byte_count++;
        if (!fin)
            return 1'b0;

        // Verdict for the whole file.
        if (glb_file)
        begin
            if (phase == glb_chk_pkg::PH_CHUNK_HDR && hdr_bytes != 0
                && first_err == glb_chk_pkg::ST_OK)
                first_err = glb_chk_pkg::ST_TRUNC;
            if (byte_count < glb_chk_pkg::MIN_BINARY_SIZE || bad_version
                || declared_len != byte_count)
                st = glb_chk_pkg::ST_HEADER;
            else
                st = first_err;
            v.status      = st;
            v.is_binary   = 1'b1;
            v.chunk_count = chunks_taken;
            if (st == glb_chk_pkg::ST_OK)
            begin
                v.json_offset = json_off;
                v.json_length = json_len;
                v.bin_present = bin_found;
                v.bin_offset  = bin_off;
                v.bin_length  = bin_len;
            end
        end
        else
            v.json_length = byte_count;
        clear_parse();
        return 1'b1;
    endfunction

    // File building.
    task automatic append_byte(input logic [7:0] value);
        file_bytes.insert(file_bytes.size(), value);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            append_byte(w[8*k +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] kind, input logic [31:0] field, input int body);
        plan_kind[plan_n]  = kind;
        plan_field[plan_n] = field;
        plan_body[plan_n]  = body;
        plan_n++;
    endtask

    task automatic emit_glb(input logic [31:0] ver, input int delta);
        int total;
        total = 12;
        for (int k = 0; k < plan_n; k++)
            total += 8 + plan_body[k];
        put_word(glb_chk_pkg::GLB_MAGIC);
        put_word(ver);
        put_word(32'(total + delta));
        for (int k = 0; k < plan_n; k++)
        begin
            put_word(plan_field[k]);
            put_word(plan_kind[k]);
            repeat (plan_body[k]) append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Make the declared length match the real size again.
    task automatic patch_length();
        logic [31:0] size;
        size = 32'(file_bytes.size());
        if (file_bytes.size() >= 12)
            for (int k = 0; k < 4; k++)
                file_bytes[8 + k] = size[8*k +: 8];
    endtask

    task automatic cut_file(input int n);
        for (int k = 0; k < n && file_bytes.size() > 1; k++)
            void'(file_bytes.pop_back());
    endtask

    task automatic build_directed(input row_t row);
        file_bytes.delete();
        plan_n = 0;
        case (row.shape)
            SH_PLAIN:
                for (int k = 0; k < row.a; k++)
                    if (row.b < 0)
                        append_byte(k == 0 ? 8'h7b : 8'($urandom_range(0, 255)));
                    else
                        append_byte(row.b[7:0]);
            SH_MAGIC:
            begin
                put_word(glb_chk_pkg::GLB_MAGIC);
                repeat (row.a - 4) append_byte(8'h00);
            end
            SH_GLB:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 32'(row.a), row.a);
                if (row.b >= 0)
                    add_chunk(glb_chk_pkg::KIND_BIN, 32'(row.b), row.b);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_BAD_VER:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(32'(row.a), 0);
            end
            SH_BAD_LEN:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, row.a);
            end
            SH_JSON_EMPTY:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 0, 0);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_BIN_FIRST:
            begin
                add_chunk(glb_chk_pkg::KIND_BIN, 4, 4);
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_OTHER_FIRST:
            begin
                add_chunk(32'(row.a), 4, 4);
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_JSON_TWICE:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_BIN_TWICE:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                add_chunk(glb_chk_pkg::KIND_BIN, 4, 4);
                add_chunk(glb_chk_pkg::KIND_BIN, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_UNALIGNED:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 32'(row.a), 8);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_OVERSIZE:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 32'h7FFF_FFFC, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_CUT_HDR:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
                repeat (row.a) append_byte(8'($urandom_range(0, 255)));
                patch_length();
            end
            SH_THREE:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                add_chunk(glb_chk_pkg::KIND_BIN, 8, 8);
                add_chunk(32'(row.a), 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            SH_MID_OTHER:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                add_chunk(32'(row.a), 4, 4);
                add_chunk(glb_chk_pkg::KIND_BIN, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
            end
            default:
            begin
                add_chunk(glb_chk_pkg::KIND_JSON, 4, 4);
                emit_glb(glb_chk_pkg::GLB_VERSION, 0);
                repeat (row.a) append_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Random file: mostly well-formed containers, some plain files and damaged ones.
    task automatic make_random_file();
        int          len;
        int          k;
        int          j;
        int          delta;
        logic [31:0] ver;
        logic [31:0] kind;
        file_bytes.delete();
        plan_n = 0;
        if ($urandom_range(0, 99) < 10)
        begin
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            repeat (len) append_byte(8'($urandom_range(0, 255)));
            return;
        end

        if ($urandom_range(0, 19) != 0)
        begin
            len = ($urandom_range(0, 19) == 0) ? 0 : 4 * $urandom_range(1, 6);
            add_chunk(glb_chk_pkg::KIND_JSON, 32'(len), len);
        end
        if ($urandom_range(0, 4) < 3)
        begin
            len = 4 * $urandom_range(0, 6);
            add_chunk(glb_chk_pkg::KIND_BIN, 32'(len), len);
        end
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 7))
                0:       kind = glb_chk_pkg::KIND_JSON;
                1:       kind = glb_chk_pkg::KIND_BIN;
                default: kind = $urandom;
            endcase
            len = 4 * $urandom_range(0, 3);
            add_chunk(kind, 32'(len), len);
        end

        // Occasionally swap the kind fields of two chunks, putting them out of order.
        if (plan_n >= 2 && $urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, plan_n - 1);
            j = $urandom_range(0, plan_n - 1);
            kind = plan_kind[k];
            plan_kind[k] = plan_kind[j];
            plan_kind[j] = kind;
        end
        // Occasionally a length field that is unaligned or simply wrong.
        if (plan_n > 0 && $urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, plan_n - 1);
            if ($urandom_range(0, 1) == 0)
                plan_field[k] = plan_field[k] + $urandom_range(1, 3);
            else
                plan_field[k] = $urandom;
        end

        ver   = ($urandom_range(0, 19) == 0) ? $urandom : glb_chk_pkg::GLB_VERSION;
        delta = 0;
        if ($urandom_range(0, 19) == 0)
            delta = $urandom_range(0, 1) ? 4 : -4;
        emit_glb(ver, delta);

        // Byte-level damage after the fact.
        if ($urandom_range(0, 4) == 0)
            case ($urandom_range(0, 3))
                0:
                begin
                    k = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
                end
                1:
                begin
                    cut_file($urandom_range(1, 12));
                    patch_length();
                end
                2:
                    cut_file($urandom_range(1, 12));
                default:
                begin
                    repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
                    patch_length();
                end
            endcase
    endtask

    // One byte transfer, after an optional idle stretch.
    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap,
                             output bit got, output glb_chk_pkg::verdict_t v);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.final_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        got = predict_byte(b, fin, v);
        bytes_sent++;
    endtask

    task automatic send_file(input bit use_want, input glb_chk_pkg::verdict_t want);
        bit                    got;
        glb_chk_pkg::verdict_t v;
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < file_bytes.size(); k++)
        begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1, tx_calm ? 0 : idle_len(),
                      got, v);
            if (got)
                verdicts_due.insert(verdicts_due.size(), use_want ? want : v);
        end
        files_sent++;
    endtask

    // Stop sending and wait for every outstanding verdict.
    task automatic drain_verdicts();
        byte_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain_verdicts();
        repeat (LATENCY_PAD) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        chunk_limit = value;
        settings_used++;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch in %s at verdict %0d: got 0x%0h, expected 0x%0h",
                     what, verdicts_seen, got, want);
        fail_count++;
    endtask

    // Verdict receiver: random stalls, with stretches of steady acceptance.
    initial
    begin
        rx_calm  = 1'b0;
        rx_stall = 0;
        verdict_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_stall > 0)
            begin
                verdict_ch.ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    rx_stall = idle_len();
            end
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
        end
    end

    // Verdict checker: every transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        glb_chk_pkg::verdict_t want;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdicts_due.size() == 0)
                flag_mismatch("verdict with nothing expected", 32'(verdict_ch.status), 32'd0);
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict_ch.status != want.status)
                    flag_mismatch("status", 32'(verdict_ch.status), 32'(want.status));
                if (verdict_ch.is_binary != want.is_binary)
                    flag_mismatch("is_binary", 32'(verdict_ch.is_binary),
                                  32'(want.is_binary));
                if (verdict_ch.json_offset != want.json_offset)
                    flag_mismatch("json_offset", verdict_ch.json_offset, want.json_offset);
                if (verdict_ch.json_length != want.json_length)
                    flag_mismatch("json_length", verdict_ch.json_length, want.json_length);
                if (verdict_ch.bin_present != want.bin_present)
                    flag_mismatch("bin_present", 32'(verdict_ch.bin_present),
                                  32'(want.bin_present));
                if (verdict_ch.bin_offset != want.bin_offset)
                    flag_mismatch("bin_offset", verdict_ch.bin_offset, want.bin_offset);
                if (verdict_ch.bin_length != want.bin_length)
                    flag_mismatch("bin_length", verdict_ch.bin_length, want.bin_length);
                if (verdict_ch.chunk_count != want.chunk_count)
                    flag_mismatch("chunk_count", 32'(verdict_ch.chunk_count),
                                  32'(want.chunk_count));
                status_seen[want.status]++;
            end
            verdicts_seen++;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdicts_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        int limits[7];
        int phase_bytes;
        int phase_files;

        limits = '{1, 65535, 2, 0, 3, RANDOM_LIMIT, 4096};
        fail_count    = 0;
        cycle_count   = 0;
        bytes_sent    = 0;
        files_sent    = 0;
        verdicts_seen = 0;
        settings_used = 1;
        tx_calm       = 1'b0;
        for (int k = 0; k < 8; k++)
            status_seen[k] = 0;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= '0;
        byte_ch.final_byte <= 1'b0;
        chunk_limit = glb_chk_pkg::LIMIT_RESET;
        clear_parse();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files at the reset chunk limit.
        plan.insert(plan.size(), plan_row(SH_PLAIN, 1, 8'h00, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 0, 0, 1, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_PLAIN, 1, 8'hFF, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 0, 0, 1, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_PLAIN, 3, 8'hFF, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 0, 0, 3, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_PLAIN, 24, -1, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 0, 0, 24, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_MAGIC, 4, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_MAGIC, 19, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_GLB, 4, -1, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 1, 20, 4, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_GLB, 8, 4, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 1, 20, 8, 1, 36, 4, 2)));
        plan.insert(plan.size(), plan_row(SH_GLB, 4, 0, 1,
                    verdict_of(glb_chk_pkg::ST_OK, 1, 20, 4, 1, 32, 0, 2)));
        plan.insert(plan.size(), plan_row(SH_GLB, 24, 24, 0, '0));
        plan.insert(plan.size(), plan_row(SH_BAD_VER, 1, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_BAD_VER, -1, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_BAD_LEN, 4, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_BAD_LEN, -4, 0, 1,
                    verdict_of(glb_chk_pkg::ST_HEADER, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_JSON_EMPTY, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_JSON_ORD, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_BIN_FIRST, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_BIN_ORD, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_OTHER_FIRST, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_NO_JSON, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_OTHER_FIRST, -1, 0, 1,
                    verdict_of(glb_chk_pkg::ST_NO_JSON, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_JSON_TWICE, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_JSON_ORD, 1, 0, 0, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_BIN_TWICE, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_BIN_ORD, 1, 0, 0, 0, 0, 0, 2)));
        plan.insert(plan.size(), plan_row(SH_UNALIGNED, 5, 0, 1,
                    verdict_of(glb_chk_pkg::ST_CHUNK_LEN, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_OVERSIZE, 0, 0, 1,
                    verdict_of(glb_chk_pkg::ST_CHUNK_LEN, 1, 0, 0, 0, 0, 0, 0)));
        plan.insert(plan.size(), plan_row(SH_CUT_HDR, 3, 0, 1,
                    verdict_of(glb_chk_pkg::ST_TRUNC, 1, 0, 0, 0, 0, 0, 1)));
        plan.insert(plan.size(), plan_row(SH_THREE, -1, 0, 0, '0));
        plan.insert(plan.size(), plan_row(SH_MID_OTHER, 0, 0, 0, '0));
        plan.insert(plan.size(), plan_row(SH_TRAILING, 4, 0, 0, '0));

        foreach (plan[k])
        begin
            build_directed(plan[k]);
            send_file(plan[k].typed, plan[k].want);
        end

        // Random files under a sequence of chunk limits, extremes included.
        foreach (limits[p])
        begin
            if (limits[p] == RANDOM_LIMIT)
                write_limit(16'($urandom_range(1, 65535)));
            else
                write_limit(16'(limits[p]));
            phase_bytes = 0;
            phase_files = 0;
            while (phase_bytes < BYTES_PER_LIMIT || phase_files < FILES_PER_LIMIT)
            begin
                make_random_file();
                phase_bytes += file_bytes.size();
                phase_files++;
                send_file(1'b0, '0);
                // Now and then hold off until the checker has caught up.
                if ($urandom_range(0, 9) == 0)
                    drain_verdicts();
            end
        end

        drain_verdicts();
        repeat (2 * LATENCY_PAD) @(posedge clk);

        $display("Run covered %0d files (%0d bytes) and %0d verdicts under %0d chunk limits.",
                 files_sent, bytes_sent, verdicts_seen, settings_used);
        $display("Verdicts per status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/glb_chk_pkg.sv
rtl/core/glb_chk_ifs.sv
rtl/core/glb_chk_in_stage.sv
rtl/core/glb_chk_core.sv
rtl/core/glb_chk_out_reg.sv
rtl/core/glb_container_chunk_checker.sv
tb/tb_glb_container_chunk_checker.sv
